### src/ffva_pkg.sv
// ---------------------------------------------------------------------------
// ffva_pkg: shared types and constants for the first-free voice allocator
// Field widths, register map codes, reset values and the configuration
// bundle passed from the register block to the allocator core.
// ---------------------------------------------------------------------------
package ffva_pkg;

    localparam int SPM_W     = 16;
    localparam int LIMIT_W   = 7;
    localparam int LEN_W     = 24;
    localparam int OFF_W     = 16;
    localparam int ACT_W     = 7;
    localparam int VOICE_W   = 7;
    localparam int OUT_OFF_W = 8;
    localparam int FREE_W    = 48;
    localparam int CLOCK_W   = 40;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    localparam logic [SPM_W-1:0]   SPM_RESET   = 16'd11290;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Register index, taken from paddr[3:2].
    localparam logic [1:0] REG_SAMPLES_PER_MS   = 2'd0;
    localparam logic [1:0] REG_ACTIVE_LIMIT     = 2'd1;
    localparam logic [1:0] REG_USE_ACTIVE_INPUT = 2'd2;

    typedef struct packed {
        logic [SPM_W-1:0]   samples_per_ms;
        logic [LIMIT_W-1:0] active_limit;
        logic               use_active_input;
    } t_cfg;

endpackage

### src/ffva_ram.sv
// ---------------------------------------------------------------------------
// ffva_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ---------------------------------------------------------------------------
module ffva_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ffva_cfg.sv
// ---------------------------------------------------------------------------
// ffva_cfg: configuration registers behind an APB-style port
// Three registers at byte addresses 0, 4 and 8, decoded from paddr[3:2]; index 3 is ignored.
// ---------------------------------------------------------------------------
module ffva_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffva_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffva_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffva_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ffva_pkg::t_cfg                o_cfg
);
    import ffva_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_ms   <= SPM_RESET;
            r_cfg.active_limit     <= LIMIT_RESET;
            r_cfg.use_active_input <= 1'b0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_SAMPLES_PER_MS: begin
                    r_cfg.samples_per_ms <= pwdata[SPM_W-1:0];
                end
                REG_ACTIVE_LIMIT: begin
                    r_cfg.active_limit <= pwdata[LIMIT_W-1:0];
                end
                REG_USE_ACTIVE_INPUT: begin
                    r_cfg.use_active_input <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SAMPLES_PER_MS:   prdata = PDATA_W'(r_cfg.samples_per_ms);
            REG_ACTIVE_LIMIT:     prdata = PDATA_W'(r_cfg.active_limit);
            REG_USE_ACTIVE_INPUT: prdata = PDATA_W'(r_cfg.use_active_input);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### src/first_free_voice_allocator.sv
// ---------------------------------------------------------------------------
// first_free_voice_allocator: first-free polyphonic voice allocator
// One input word per audio sample. Free times live in a RAM; each accepted trigger
// scans it for the lowest-numbered free voice and books that voice, if any.
//
//   channel  direction  handshake               payload
//   in       in         i_in_valid/o_in_stall   trigger, length, offset, count, clear
//   out      out        o_out_valid/i_out_stall voice id, length, offset
//   cfg      in         APB psel/penable/pready three registers, 32-bit data
//
// A word with an accepted trigger scans the first active voices, stopping at the first
// free one (active = eligible voice count); the scan issues one RAM read per cycle
// and compares each entry in the cycle after its read is issued.
// A word without an accepted trigger skips the scan.
// A word with clear set first runs the zeroing sweep over all VOICE_COUNT entries.
// After reset the same sweep runs with the input stalled.
// A stalled output holds the block in its final state until the word is taken.
// ---------------------------------------------------------------------------
module first_free_voice_allocator #(
    parameter int VOICE_COUNT = 64,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_trigger,
    input  logic [ffva_pkg::LEN_W-1:0]          i_length_ms,
    input  logic signed [ffva_pkg::OFF_W-1:0]   i_offset,
    input  logic [ffva_pkg::ACT_W-1:0]          i_active_count,
    input  logic                                i_clear_all,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ffva_pkg::VOICE_W-1:0]        o_voice_id,
    output logic [ffva_pkg::LEN_W-1:0]          o_length_out,
    output logic [ffva_pkg::OUT_OFF_W-1:0]      o_offset_out,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffva_pkg::PADDR_W-1:0]        paddr,
    input  logic [ffva_pkg::PDATA_W-1:0]        pwdata,
    output logic [ffva_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import ffva_pkg::*;

    localparam int IDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
    localparam int NOW_W  = CLOCK_W + FRAC_BITS;
    localparam int PROD_W = SPM_W + LEN_W;
    localparam int SUM_W  = NOW_W + 1;
    localparam int CMP_W  = (NOW_W > FREE_W) ? NOW_W : FREE_W;
    localparam int EXT_W  = (SUM_W > FREE_W) ? SUM_W : FREE_W + 1;
    localparam logic [OFF_W:0] ONE_SAMPLE = (OFF_W + 1)'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    t_cfg w_cfg;

    t_state                  r_state;
    logic [IDX_W-1:0]        r_sweep;
    logic                    r_item;
    logic                    r_go;
    logic [LEN_W-1:0]        r_len;
    logic [FRAC_BITS-1:0]    r_off;
    logic [CNT_W-1:0]        r_active;
    logic [CLOCK_W-1:0]      r_clock;
    logic [PROD_W-1:0]       r_prod;
    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_issue;
    logic                    r_cmp_vld;
    logic [CNT_W-1:0]        r_cmp_idx;
    logic                    r_hit;
    logic [CNT_W-1:0]        r_hit_idx;
    logic                    r_out_valid;
    logic [VOICE_W-1:0]      r_voice;
    logic [LEN_W-1:0]        r_len_out;
    logic [OUT_OFF_W-1:0]    r_off_out;

    logic                    w_off_neg;
    logic                    w_off_ok;
    logic [ACT_W-1:0]        w_act_sel;
    logic [CNT_W-1:0]        w_active;
    logic [NOW_W-1:0]        w_now;
    logic                    w_free_le;
    logic [SUM_W-1:0]        w_diff;
    logic                    w_under;
    logic [EXT_W-1:0]        w_diff_ext;
    logic [FREE_W-1:0]       w_book;
    logic                    w_out_free;
    logic                    w_load;
    logic                    w_ram_we;
    logic [IDX_W-1:0]        w_ram_waddr;
    logic [FREE_W-1:0]       w_ram_wdata;
    logic [FREE_W-1:0]       w_ram_rdata;
    logic [CNT_W-1:0]        w_voice_1b;

    ffva_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ffva_ram #(
        .WIDTH (FREE_W),
        .DEPTH (VOICE_COUNT)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Offset of one sample or more blocks the trigger; negative clamps to zero.
    assign w_off_neg = i_offset[OFF_W-1];
    assign w_off_ok  = w_off_neg || ({1'b0, i_offset} < ONE_SAMPLE);

    assign w_act_sel = w_cfg.use_active_input ? i_active_count : w_cfg.active_limit;
    assign w_active  = (int'(w_act_sel) > VOICE_COUNT) ? CNT_W'(VOICE_COUNT)
                                                       : CNT_W'(w_act_sel);

    assign w_now     = NOW_W'(r_clock) << FRAC_BITS;
    assign w_free_le = CMP_W'(w_ram_rdata) <= CMP_W'(w_now);

    // Booking end: clock + span - offset, floored at zero, saturated at the top.
    assign w_under    = r_sum < SUM_W'(r_off);
    assign w_diff     = r_sum - SUM_W'(r_off);
    assign w_diff_ext = EXT_W'(w_diff);
    assign w_book     = w_under ? '0 :
                        (w_diff_ext > EXT_W'(FREE_MAX)) ? FREE_MAX : FREE_W'(w_diff_ext);

    assign w_ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_sweep : r_hit_idx[IDX_W-1:0];
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : w_book;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_DONE) && w_out_free;
    assign w_voice_1b = r_hit_idx + CNT_W'(1);

    // Span product and sum run every cycle from held operands; both settle
    // by the write state, which the scan reaches only after its first read and compare.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_cfg.samples_per_ms) * PROD_W'(r_len);
        r_sum  <= SUM_W'(w_now) + SUM_W'(r_prod >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_item      <= 1'b0;
            r_go        <= 1'b0;
            r_clock     <= '0;
            r_issue     <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_sweep == IDX_W'(VOICE_COUNT - 1)) begin
                        r_sweep <= '0;
                        if (!r_item) begin
                            r_state <= S_IDLE;
                        end else if (r_go) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item    <= 1'b1;
                        r_go      <= i_trigger && w_off_ok;
                        r_len     <= i_length_ms;
                        r_off     <= w_off_neg ? '0 : i_offset[FRAC_BITS-1:0];
                        r_active  <= w_active;
                        r_issue   <= '0;
                        r_cmp_vld <= 1'b0;
                        r_hit     <= 1'b0;
                        if (i_clear_all) begin
                            r_clock <= '0;
                            r_state <= S_CLEAR;
                        end else if (i_trigger && w_off_ok) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // Reads are issued one per cycle; the compare sees the
                    // entry read in the previous cycle.
                    if (r_cmp_vld && w_free_le) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_cmp_idx;
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_WRITE;
                    end else if (r_issue < r_active) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_issue;
                        r_issue   <= r_issue + 1'b1;
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_DONE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_voice     <= r_hit ? VOICE_W'(w_voice_1b) : '0;
                        r_len_out   <= r_hit ? r_len : '0;
                        r_off_out   <= r_hit ? OUT_OFF_W'(r_off) : '0;
                        r_clock     <= r_clock + 1'b1;
                        r_item      <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_voice_id     = r_voice;
    assign o_length_out   = r_len_out;
    assign o_offset_out   = r_off_out;

    // The RAM is written only by the clearing sweep or a booking.
    a_ram_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_hit || r_state == S_CLEAR))
        else $error("free-time RAM written outside a sweep or a booking");

    // A compare in flight always refers to an eligible voice.
    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmp_vld) |-> (r_cmp_idx < r_active))
        else $error("scan compared a voice beyond the eligible count");

    // Each finished word advances the sample clock by exactly one.
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_clock == $past(r_clock) + 1'b1))
        else $error("sample clock did not advance by one per word");

    // A result with no voice carries zero length and offset.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_voice_id == '0) |-> (o_length_out == '0 && o_offset_out == '0))
        else $error("result without a voice has nonzero fields");

endmodule

### tb/sv/tb_first_free_voice_allocator.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_first_free_voice_allocator: self-checking bench for the voice allocator
// Sends sample ticks through the valid/stall input channel, predicts the
// grant of every accepted word from a local model of the free times and the
// sample clock, and checks each grant word as it leaves the block. The run
// steps through several register settings and idling patterns, including a
// long output hold-off and a pause that drains the block.
// ---------------------------------------------------------------------------
module tb_first_free_voice_allocator;
    import ffva_pkg::*;

    localparam int VOICES       = 64;
    localparam int FRAC         = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 131;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic               trigger;
        logic [LEN_W-1:0]   length_ms;
        logic [OFF_W-1:0]   offset;
        logic [ACT_W-1:0]   active_count;
        logic               clear_all;
    } t_tick;

    typedef struct packed {
        logic [VOICE_W-1:0]   voice_id;
        logic [LEN_W-1:0]     length_out;
        logic [OUT_OFF_W-1:0] offset_out;
    } t_grant;

    // Holds the predicted free time of every voice and the grants still owed.
    class t_grant_scoreboard;
        logic [FREE_W-1:0]  free_at [VOICES];
        logic [CLOCK_W-1:0] sample_clock;
        logic [SPM_W-1:0]   spm;
        logic [LIMIT_W-1:0] limit;
        logic               use_count;
        t_grant             expected_grants [$];
        int                 errors;

        function new();
            foreach (free_at[i]) free_at[i] = '0;
            sample_clock = '0;
            spm          = SPM_RESET;
            limit        = LIMIT_RESET;
            use_count    = 1'b0;
            errors       = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_SAMPLES_PER_MS:   spm = val[SPM_W-1:0];
                REG_ACTIVE_LIMIT:     limit = val[LIMIT_W-1:0];
                REG_USE_ACTIVE_INPUT: use_count = val[0];
                default: ;
            endcase
        endfunction

        function void note_tick(t_tick t);
            t_grant      g;
            logic [63:0] now;
            logic [63:0] span;
            logic [63:0] booked;
            logic [63:0] off;
            int          eligible;
            int          pick;
            g = '0;
            if (t.clear_all) begin
                foreach (free_at[i]) free_at[i] = '0;
                sample_clock = '0;
            end
            eligible = use_count ? int'(t.active_count) : int'(limit);
            if (eligible > VOICES) eligible = VOICES;
            // A negative offset is always below one sample.
            if (t.trigger && (t.offset[OFF_W-1] || t.offset < (16'd1 << FRAC))) begin
                now = 64'(sample_clock) << FRAC;
                pick = -1;
                for (int i = 0; i < eligible && pick < 0; i++) begin
                    if (64'(free_at[i]) <= now) pick = i;
                end
                if (pick >= 0) begin
                    off = t.offset[OFF_W-1] ? 64'd0 : 64'(t.offset);
                    span = (64'(spm) * 64'(t.length_ms)) >> FRAC;
                    booked = now + span;
                    booked = (booked < off) ? 64'd0 : booked - off;
                    if (booked > 64'(FREE_MAX)) booked = 64'(FREE_MAX);
                    free_at[pick] = booked[FREE_W-1:0];
                    g.voice_id = VOICE_W'(pick + 1);
                    g.length_out = t.length_ms;
                    g.offset_out = off[OUT_OFF_W-1:0];
                end
            end
            sample_clock = sample_clock + 1'b1;
            expected_grants.push_back(g);
        endfunction

        function void check_grant(t_grant got);
            t_grant want;
            if (expected_grants.size() == 0) begin
                $display("%0t: grant word with none expected: voice %0d length %0d offset %0d",
                         $time, got.voice_id, got.length_out, got.offset_out);
                errors++;
                return;
            end
            want = expected_grants.pop_front();
            if (got.voice_id !== want.voice_id) begin
                $display("%0t: voice expected %0d actual %0d",
                         $time, want.voice_id, got.voice_id);
                errors++;
            end
            if (got.length_out !== want.length_out) begin
                $display("%0t: length_out expected %0d actual %0d",
                         $time, want.length_out, got.length_out);
                errors++;
            end
            if (got.offset_out !== want.offset_out) begin
                $display("%0t: offset_out expected %0d actual %0d",
                         $time, want.offset_out, got.offset_out);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_trigger;
    logic [LEN_W-1:0]     i_length_ms;
    logic [OFF_W-1:0]     i_offset;
    logic [ACT_W-1:0]     i_active_count;
    logic                 i_clear_all;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [VOICE_W-1:0]   o_voice_id;
    logic [LEN_W-1:0]     o_length_out;
    logic [OUT_OFF_W-1:0] o_offset_out;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    t_grant_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int long_holds_wanted = 0;
    int long_holds_done = 0;
    int cycles = 0;

    first_free_voice_allocator #(
        .VOICE_COUNT(VOICES),
        .FRAC_BITS  (FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_trigger     (i_trigger),
        .i_length_ms   (i_length_ms),
        .i_offset      (i_offset),
        .i_active_count(i_active_count),
        .i_clear_all   (i_clear_all),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_voice_id    (o_voice_id),
        .o_length_out  (o_length_out),
        .o_offset_out  (o_offset_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d grant words outstanding",
                     $time, sb.expected_grants.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: checks each word taken and decides the stall for the next cycle.
    initial begin : grant_receiver
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
                sb.check_grant('{o_voice_id, o_length_out, o_offset_out});
            if (long_holds_wanted > long_holds_done) begin
                hold_left = LONG_HOLD;
                long_holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic t_tick mk(logic trig, logic [LEN_W-1:0] len, logic [OFF_W-1:0] off,
                                 logic [ACT_W-1:0] act, logic clr);
        t_tick t;
        t = '{trig, len, off, act, clr};
        return t;
    endfunction

    task automatic send_tick(input t_tick t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_trigger      <= t.trigger;
        i_length_ms    <= t.length_ms;
        i_offset       <= t.offset;
        i_active_count <= t.active_count;
        i_clear_all    <= t.clear_all;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_tick(t);
    endtask

    // Stops offering and waits until every owed grant has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_grants.size() != 0);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] rd;
        case (idx)
            REG_SAMPLES_PER_MS: mask = 32'h0000_FFFF;
            REG_ACTIVE_LIMIT:   mask = 32'h0000_007F;
            default:            mask = 32'h0000_0001;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_register(idx, val);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== (val & mask)) begin
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $time, idx, val & mask, rd);
            sb.errors++;
        end
    endtask

    initial begin : stimulus
        t_tick directed [$];
        t_tick t;
        int    phase_spm   [PHASES] = '{11290, 0, 65535, -1, 11290, -1, 65535, 256};
        int    phase_limit [PHASES] = '{64, 64, 64, 0, 4, 64, 1, 33};
        int    phase_use   [PHASES] = '{0, 1, 0, 0, 0, 1, 1, 0};
        int    sel;
        sb = new();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_trigger      <= 1'b0;
        i_length_ms    <= '0;
        i_offset       <= '0;
        i_active_count <= '0;
        i_clear_all    <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: underflow held at zero, offset limits, clears.
        directed = '{
            mk(1'b1, 24'd0,       16'd200,   7'd0,  1'b0),
            mk(1'b1, 24'hFFFFFF,  16'd0,     7'd64, 1'b0),
            mk(1'b1, 24'd256,     16'd255,   7'd0,  1'b0),
            mk(1'b1, 24'd256,     16'd256,   7'd0,  1'b0),
            mk(1'b1, 24'd256,     16'h7FFF,  7'd0,  1'b0),
            mk(1'b1, 24'd512,     16'hFFFF,  7'd0,  1'b0),
            mk(1'b1, 24'd1,       16'h8000,  7'd64, 1'b0),
            mk(1'b0, 24'hFFFFFF,  16'h00FF,  7'd64, 1'b0),
            mk(1'b1, 24'd100,     16'd10,    7'd0,  1'b1),
            mk(1'b0, 24'd0,       16'd0,     7'd0,  1'b1),
            mk(1'b1, 24'd0,       16'd0,     7'd0,  1'b0)
        };
        foreach (directed[i]) send_tick(directed[i]);
        drain();
        repeat (8) @(posedge i_clk);

        // Count taken from the word: all busy, zero eligible, full range.
        reg_write(REG_USE_ACTIVE_INPUT, 32'd1);
        directed = '{
            mk(1'b1, 24'hFFFFFF,  16'd0,     7'd1,  1'b1),
            mk(1'b1, 24'd100,     16'd0,     7'd1,  1'b0),
            mk(1'b1, 24'd100,     16'd0,     7'd0,  1'b0),
            mk(1'b1, 24'd100,     16'd0,     7'd2,  1'b0),
            mk(1'b1, 24'h800000,  16'd128,   7'd64, 1'b0),
            mk(1'b1, 24'd5,       16'd255,   7'd64, 1'b0)
        };
        foreach (directed[i]) send_tick(directed[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            repeat (8) @(posedge i_clk);
            reg_write(REG_SAMPLES_PER_MS,
                      (phase_spm[p] < 0) ? $urandom_range(0, 65535) : phase_spm[p]);
            reg_write(REG_ACTIVE_LIMIT, phase_limit[p]);
            reg_write(REG_USE_ACTIVE_INPUT, phase_use[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 88; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (p == 0 && n == 40) long_holds_wanted++;
                // Let the block run dry once before going on.
                if (p == 4 && n == 60) drain();
                t.trigger   = ($urandom_range(99) < 65);
                t.clear_all = ($urandom_range(99) < 3);
                sel = $urandom_range(99);
                if (sel < 80)      t.length_ms = LEN_W'($urandom_range(0, 2047));
                else if (sel < 92) t.length_ms = LEN_W'($urandom_range(0, 65535));
                else               t.length_ms = LEN_W'($urandom);
                sel = $urandom_range(99);
                if (sel < 70)      t.offset = OFF_W'($urandom_range(0, 255));
                else if (sel < 85) t.offset = OFF_W'($urandom) | 16'h8000;
                else               t.offset = OFF_W'($urandom);
                t.active_count = $urandom_range(1) ? ACT_W'($urandom_range(0, 8))
                                                   : ACT_W'($urandom_range(0, 64));
                send_tick(t);
            end
        end

        i_in_valid <= 1'b0;
        stall_pct = 0;
        while (sb.expected_grants.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
